### hw/rtl/tcb_pkg.sv
// ----------------------------------------------------------------------------
// tcb_pkg
// Shared codes and controller/datapath interface types for the character-cell
// text buffer with caret.
// ----------------------------------------------------------------------------
package tcb_pkg;

    // Item function codes.
    localparam logic [1:0] FUNC_KEY  = 2'd0;
    localparam logic [1:0] FUNC_CHAR = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // Key codes.
    localparam logic [3:0] KEY_HOME   = 4'd0;
    localparam logic [3:0] KEY_END    = 4'd1;
    localparam logic [3:0] KEY_PGUP   = 4'd2;
    localparam logic [3:0] KEY_PGDN   = 4'd3;
    localparam logic [3:0] KEY_LEFT   = 4'd4;
    localparam logic [3:0] KEY_RIGHT  = 4'd5;
    localparam logic [3:0] KEY_UP     = 4'd6;
    localparam logic [3:0] KEY_DOWN   = 4'd7;
    localparam logic [3:0] KEY_DELETE = 4'd8;

    // Character codes with special handling.
    localparam logic [15:0] CH_BS    = 16'd8;
    localparam logic [15:0] CH_TAB   = 16'd9;
    localparam logic [15:0] CH_LF    = 16'd10;
    localparam logic [15:0] CH_CR    = 16'd13;
    localparam logic [15:0] CH_ESC   = 16'd27;
    localparam logic [15:0] CH_SPACE = 16'h0020;

    // Tab stops fall on multiples of this column count.
    localparam int TAB_WIDTH = 8;

    // Configuration register indexes.
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // latch the incoming request
        logic key_move;    // apply a caret movement key
        logic rd_cell;     // read the requested cell
        logic load_space;  // result data becomes space
        logic load_rdata;  // result data becomes the cell just read
        logic put;         // store a character at the caret and advance
        logic ctl_char;    // apply line feed or return
        logic bs_move;     // move the caret one column left
        logic del_start;   // start a row shift at the (next) caret column
        logic del_rd;      // read the cell right of the shift index
        logic del_wr;      // write the read cell at the shift index
        logic del_tail;    // write space into the last column of the row
        logic rep_dec;     // one repetition done
        logic clr_start;   // start a clearing sweep and home the caret
        logic clr_step;    // clear one cell of the sweep
        logic out_load;    // load the result register
    } tcb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] func;
        logic       key_is_move;
        logic       key_is_del;
        logic       is_esc;
        logic       is_bs;
        logic       is_tab;
        logic       is_ctl;
        logic       reps_zero;
        logic       reps_last;
        logic       read_ok;
        logic       bs_ok;
        logic       tab_stop;
        logic       shift_more;
        logic       clr_last;
    } tcb_status_t;

endpackage

### hw/rtl/text_cell_buffer_with_caret_unit.sv
// A caret key moves the caret in dispatch; a cell read passes a read state; a delete
// shifts the cells right of the caret left; a character item stores a cell per pass.
// Escape sweeps every cell in use (screen_columns * screen_rows), one cell per cycle.
// One request is worked at a time; the next is taken while the last result waits.
// Reset, and a register write in idle or mid-sweep, clear the screen in use to spaces,
// one cell per cycle. Reset and writes home the caret; no request is taken meanwhile.
// ----------------------------------------------------------------------------
// text_cell_buffer_with_caret_unit
// Character-cell text screen with a caret: controller and datapath joined by
// command and status structs.
// ----------------------------------------------------------------------------
module text_cell_buffer_with_caret_unit
#(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [3:0]  key_code,
    input  logic [15:0] char_code,
    input  logic [15:0] repeat_count,
    input  logic [6:0]  read_col,
    input  logic [5:0]  read_row,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  caret_col,
    output logic [5:0]  caret_row,
    output logic [15:0] cell_data
);
    import tcb_pkg::*;

    tcb_cmd_t    cmd;
    tcb_status_t status;

    // Sequencing.
    tcb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .status    (status),
        .cmd       (cmd)
    );

    // Storage and arithmetic.
    tcb_datapath
    #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .func         (func),
        .key_code     (key_code),
        .char_code    (char_code),
        .repeat_count (repeat_count),
        .read_col     (read_col),
        .read_row     (read_row),
        .caret_col    (caret_col),
        .caret_row    (caret_row),
        .cell_data    (cell_data),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

### hw/rtl/tcb_ctrl.sv
// ----------------------------------------------------------------------------
// tcb_ctrl
// Controller state machine: sequences clearing sweeps, caret moves, character
// repetitions, row shifts and cell reads, and owns the handshake flags.
// ----------------------------------------------------------------------------
module tcb_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 cfg_we,
    input  tcb_pkg::tcb_status_t status,
    output tcb_pkg::tcb_cmd_t    cmd
);
    import tcb_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR    = 8'b0000_0001,
        ST_IDLE     = 8'b0000_0010,
        ST_DISPATCH = 8'b0000_0100,
        ST_CHAR     = 8'b0000_1000,
        ST_DEL_RD   = 8'b0001_0000,
        ST_DEL_WR   = 8'b0010_0000,
        ST_READ     = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   clr_ret_reg, clr_ret_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    // A request is taken only in idle and never together with a register write.
    assign in_stall  = (state_reg != ST_IDLE) || cfg_we;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next   = state_reg;
        clr_ret_next = clr_ret_reg;
        cmd          = '0;
        cmd.accept   = accept;

        case (state_reg)
            ST_CLEAR:
            begin
                if (cfg_we)
                begin
                    cmd.clr_start = 1'b1;
                    clr_ret_next  = 1'b0;
                end
                else
                begin
                    cmd.clr_step = 1'b1;
                    if (status.clr_last)
                    begin
                        state_next = clr_ret_reg ? ST_DONE : ST_IDLE;
                    end
                end
            end

            ST_IDLE:
            begin
                if (cfg_we)
                begin
                    cmd.clr_start = 1'b1;
                    clr_ret_next  = 1'b0;
                    state_next    = ST_CLEAR;
                end
                else if (accept)
                begin
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                state_next = ST_DONE;
                case (status.func)
                    FUNC_KEY:
                    begin
                        if (status.key_is_move)
                        begin
                            cmd.key_move = 1'b1;
                        end
                        else if (status.key_is_del)
                        begin
                            cmd.del_start = 1'b1;
                            state_next    = ST_DEL_RD;
                        end
                    end
                    FUNC_CHAR:
                    begin
                        if (!status.reps_zero)
                        begin
                            state_next = ST_CHAR;
                        end
                    end
                    FUNC_READ:
                    begin
                        if (status.read_ok)
                        begin
                            cmd.rd_cell = 1'b1;
                            state_next  = ST_READ;
                        end
                        else
                        begin
                            cmd.load_space = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            // One application of the character per pass, tab may take several.
            ST_CHAR:
            begin
                if (status.is_esc)
                begin
                    cmd.clr_start = 1'b1;
                    clr_ret_next  = 1'b1;
                    state_next    = ST_CLEAR;
                end
                else if (status.is_bs && status.bs_ok)
                begin
                    cmd.bs_move   = 1'b1;
                    cmd.del_start = 1'b1;
                    state_next    = ST_DEL_RD;
                end
                else
                begin
                    cmd.put      = !status.is_bs && !status.is_ctl;
                    cmd.ctl_char = status.is_ctl;
                    if (!status.is_tab || status.tab_stop)
                    begin
                        if (status.reps_last)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cmd.rep_dec = 1'b1;
                        end
                    end
                end
            end

            ST_DEL_RD:
            begin
                if (status.shift_more)
                begin
                    cmd.del_rd = 1'b1;
                    state_next = ST_DEL_WR;
                end
                else
                begin
                    cmd.del_tail = 1'b1;
                    if (status.func == FUNC_CHAR && !status.reps_last)
                    begin
                        cmd.rep_dec = 1'b1;
                        state_next  = ST_CHAR;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DEL_WR:
            begin
                cmd.del_wr = 1'b1;
                state_next = ST_DEL_RD;
            end

            ST_READ:
            begin
                cmd.load_rdata = 1'b1;
                state_next     = ST_DONE;
            end

            // Wait for the result register to be free.
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Reset starts with a clearing sweep of the screen.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_ret_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_ret_reg   <= clr_ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hw/rtl/tcb_datapath.sv
// ----------------------------------------------------------------------------
// tcb_datapath
// Cell memory, caret, screen size registers, request latch, sweep and shift
// counters and the result register.
// ----------------------------------------------------------------------------
module tcb_datapath
#(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic [1:0]           func,
    input  logic [3:0]           key_code,
    input  logic [15:0]          char_code,
    input  logic [15:0]          repeat_count,
    input  logic [6:0]           read_col,
    input  logic [5:0]           read_row,
    output logic [6:0]           caret_col,
    output logic [5:0]           caret_row,
    output logic [15:0]          cell_data,
    input  tcb_pkg::tcb_cmd_t    cmd,
    output tcb_pkg::tcb_status_t status
);
    import tcb_pkg::*;

    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_CW = $clog2(MAX_COLS + 1);
    localparam int CNT_RW = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int MEM_D  = 1 << ADDR_W;
    localparam int RST_COLS = (80 > MAX_COLS) ? MAX_COLS : 80;
    localparam int RST_ROWS = (25 > MAX_ROWS) ? MAX_ROWS : 25;

    // Screen size and caret.
    logic [CNT_CW-1:0] cols_reg;
    logic [CNT_RW-1:0] rows_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;

    // Latched request.
    logic [1:0]  func_reg;
    logic [3:0]  key_reg;
    logic [15:0] ch_reg;
    logic [15:0] reps_reg;
    logic [6:0]  rcol_reg;
    logic [5:0]  rrow_reg;

    // Sweep and shift counters.
    logic [COL_W-1:0] swc_reg;
    logic [ROW_W-1:0] swr_reg;
    logic [COL_W-1:0] idx_reg;

    // Result.
    logic [15:0] data_reg;
    logic [6:0]  out_col_reg;
    logic [5:0]  out_row_reg;
    logic [15:0] out_data_reg;

    // Memory.
    logic [15:0]       mem [MEM_D];
    logic [15:0]       rdata_reg;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [15:0]       wr_data;

    // Helper values.
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    logic [COL_W-1:0] put_col;
    logic             put_wrap;
    logic [ROW_W-1:0] row_adv;
    logic             col_more, row_more;
    logic [7:0]       sat_cols;
    logic [6:0]       sat_rows;

    assign last_col = COL_W'(cols_reg - CNT_CW'(1));
    assign last_row = ROW_W'(rows_reg - CNT_RW'(1));
    assign col_more = (32'(col_reg) + 32'd1) < 32'(cols_reg);
    assign row_more = (32'(row_reg) + 32'd1) < 32'(rows_reg);
    assign row_adv  = row_more ? ROW_W'(row_reg + ROW_W'(1)) : '0;
    assign put_wrap = !col_more;
    assign put_col  = put_wrap ? '0 : COL_W'(col_reg + COL_W'(1));

    // Register values saturated to the supported range.
    always_comb
    begin
        sat_cols = cfg_data;
        if (cfg_data == 8'd0)
        begin
            sat_cols = 8'd1;
        end
        else if (32'(cfg_data) > MAX_COLS)
        begin
            sat_cols = 8'(MAX_COLS);
        end
        sat_rows = cfg_data[6:0];
        if (cfg_data[6:0] == 7'd0)
        begin
            sat_rows = 7'd1;
        end
        else if (32'(cfg_data[6:0]) > MAX_ROWS)
        begin
            sat_rows = 7'(MAX_ROWS);
        end
    end

    // Caret next value.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we || cmd.clr_start)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (cmd.key_move)
        begin
            case (key_reg)
                KEY_HOME:  col_next = '0;
                KEY_END:   col_next = last_col;
                KEY_PGUP:  row_next = '0;
                KEY_PGDN:  row_next = last_row;
                KEY_LEFT:
                begin
                    if (col_reg != '0)
                    begin
                        col_next = col_reg - COL_W'(1);
                    end
                end
                KEY_RIGHT:
                begin
                    if (col_more)
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
                KEY_UP:
                begin
                    if (row_reg != '0)
                    begin
                        row_next = row_reg - ROW_W'(1);
                    end
                end
                KEY_DOWN:
                begin
                    if (row_more)
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
                default:
                begin
                    col_next = col_reg;
                end
            endcase
        end
        else if (cmd.put)
        begin
            col_next = put_col;
            if (put_wrap)
            begin
                row_next = row_adv;
            end
        end
        else if (cmd.ctl_char)
        begin
            row_next = row_adv;
            if (ch_reg == CH_CR)
            begin
                col_next = '0;
            end
        end
        else if (cmd.bs_move)
        begin
            col_next = col_reg - COL_W'(1);
        end
    end

    // Memory port selection.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {row_reg, col_reg};
        wr_data = CH_SPACE;
        rd_en   = 1'b0;
        rd_addr = {ROW_W'(rrow_reg), COL_W'(rcol_reg)};
        if (cmd.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = {swr_reg, swc_reg};
        end
        else if (cmd.put)
        begin
            wr_en   = 1'b1;
            wr_data = (ch_reg == CH_TAB) ? CH_SPACE : ch_reg;
        end
        else if (cmd.del_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = {row_reg, idx_reg};
            wr_data = rdata_reg;
        end
        else if (cmd.del_tail)
        begin
            wr_en   = 1'b1;
            wr_addr = {row_reg, last_col};
        end
        if (cmd.rd_cell)
        begin
            rd_en = 1'b1;
        end
        else if (cmd.del_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = {row_reg, COL_W'(idx_reg + COL_W'(1))};
        end
    end

    // Cell memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Screen size, caret and clearing sweep counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CNT_CW'(RST_COLS);
            rows_reg <= CNT_RW'(RST_ROWS);
            col_reg  <= '0;
            row_reg  <= '0;
            swc_reg  <= '0;
            swr_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_COLS)
                begin
                    cols_reg <= CNT_CW'(sat_cols);
                end
                else
                begin
                    rows_reg <= CNT_RW'(sat_rows);
                end
            end
            col_reg <= col_next;
            row_reg <= row_next;
            if (cmd.clr_start)
            begin
                swc_reg <= '0;
                swr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                if (swc_reg == last_col)
                begin
                    swc_reg <= '0;
                    swr_reg <= swr_reg + ROW_W'(1);
                end
                else
                begin
                    swc_reg <= swc_reg + COL_W'(1);
                end
            end
        end
    end

    // Request latch, repeat count, shift index and result data.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= func;
            key_reg  <= key_code;
            ch_reg   <= char_code;
            reps_reg <= repeat_count;
            rcol_reg <= read_col;
            rrow_reg <= read_row;
            data_reg <= '0;
        end
        else
        begin
            if (cmd.rep_dec)
            begin
                reps_reg <= reps_reg - 16'd1;
            end
            if (cmd.load_space)
            begin
                data_reg <= CH_SPACE;
            end
            else if (cmd.load_rdata)
            begin
                data_reg <= rdata_reg;
            end
        end
        if (cmd.del_start)
        begin
            idx_reg <= col_next;
        end
        else if (cmd.del_wr)
        begin
            idx_reg <= idx_reg + COL_W'(1);
        end
        if (cmd.out_load)
        begin
            out_col_reg  <= 7'(col_reg);
            out_row_reg  <= 6'(row_reg);
            out_data_reg <= data_reg;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        status             = '0;
        status.func        = func_reg;
        status.key_is_move = key_reg inside {[KEY_HOME:KEY_DOWN]};
        status.key_is_del  = (key_reg == KEY_DELETE);
        status.is_esc      = (ch_reg == CH_ESC);
        status.is_bs       = (ch_reg == CH_BS);
        status.is_tab      = (ch_reg == CH_TAB);
        status.is_ctl      = ch_reg inside {CH_LF, CH_CR};
        status.reps_zero   = (reps_reg == 16'd0);
        status.reps_last   = (reps_reg == 16'd1);
        status.read_ok     = (32'(rcol_reg) < 32'(cols_reg)) &&
                             (32'(rrow_reg) < 32'(rows_reg));
        status.bs_ok       = (col_reg != '0);
        status.tab_stop    = ((32'(put_col) % TAB_WIDTH) == 0);
        status.shift_more  = (32'(idx_reg) + 32'd1) < 32'(cols_reg);
        status.clr_last    = (swc_reg == last_col) && (swr_reg == last_row);
    end

    assign caret_col = out_col_reg;
    assign caret_row = out_row_reg;
    assign cell_data = out_data_reg;

endmodule

### bench/text_cell_buffer_with_caret_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_cell_buffer_with_caret_unit_tb
// Self-checking bench for the character-cell text screen. A screen tracker
// keeps its own copy of the cells, the caret and the screen size. It predicts
// the caret and cell data for every accepted request and checks each result
// in order. A directed set covers the keys, the control characters and the
// screen edges. Random requests then run at several screen sizes, with bursty
// requests and a receiver that stalls in patterns of its own.
// ----------------------------------------------------------------------------
module text_cell_buffer_with_caret_unit_tb;

    import tcb_pkg::*;

    localparam int MAX_COLS   = 128;
    localparam int MAX_ROWS   = 64;
    localparam int RESET_COLS = 80;
    localparam int RESET_ROWS = 25;

    // Function code that the block treats as a no-op.
    localparam logic [1:0] FUNC_NONE = 2'd3;

    // Wait between two register writes, long enough for a full clearing sweep.
    localparam int CLEAR_WAIT  = MAX_COLS * MAX_ROWS + 32;
    localparam int IDLE_GUARD  = 16;
    localparam int LONG_HOLD   = 300;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [6:0]  col;
        logic [5:0]  row;
        logic [15:0] data;
    } caret_result_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HALF,
        STALL_HEAVY,
        STALL_HOLD
    } stall_mode_e;

    // ------------------------------------------------------------------------
    // Screen tracker: predicted screen state plus the queue of expected results.
    // ------------------------------------------------------------------------
    class screen_tracker;
        logic [15:0]   cells [MAX_ROWS][MAX_COLS];
        int unsigned   cols;
        int unsigned   rows;
        int unsigned   ccol;
        int unsigned   crow;
        caret_result_t expected_results[$];
        int unsigned   error_count;
        int unsigned   result_count;

        function new();
            cols         = RESET_COLS;
            rows         = RESET_ROWS;
            error_count  = 0;
            result_count = 0;
            clear_screen();
        endfunction

        function void clear_screen();
            foreach (cells[r, c])
                cells[r][c] = CH_SPACE;
            ccol = 0;
            crow = 0;
        endfunction

        function int unsigned clamp_size(int unsigned value, int unsigned hi);
            if (value < 1)
                return 1;
            if (value > hi)
                return hi;
            return value;
        endfunction

        // Any register write clears the screen and homes the caret.
        function void write_register(logic idx, logic [7:0] value);
            if (idx == REG_COLS)
                cols = clamp_size(32'(value), MAX_COLS);
            else
                rows = clamp_size(32'(value & 8'h7F), MAX_ROWS);
            clear_screen();
        endfunction

        function void advance_row();
            crow++;
            if (crow >= rows)
                crow = 0;
        endfunction

        // Shift the rest of the caret row one cell left and blank the last cell.
        function void delete_cell();
            int unsigned c;
            for (c = ccol; c + 1 < cols; c++)
                cells[crow][c] = cells[crow][c + 1];
            cells[crow][cols - 1] = CH_SPACE;
        endfunction

        function void store_char(logic [15:0] ch);
            cells[crow][ccol] = ch;
            ccol++;
            if (ccol >= cols)
            begin
                ccol = 0;
                advance_row();
            end
        endfunction

        function void apply_key(logic [3:0] key);
            case (key)
                KEY_HOME:   ccol = 0;
                KEY_END:    ccol = cols - 1;
                KEY_PGUP:   crow = 0;
                KEY_PGDN:   crow = rows - 1;
                KEY_LEFT:   if (ccol > 0) ccol--;
                KEY_RIGHT:  if (ccol + 1 < cols) ccol++;
                KEY_UP:     if (crow > 0) crow--;
                KEY_DOWN:   if (crow + 1 < rows) crow++;
                KEY_DELETE: delete_cell();
                default:    ;
            endcase
        endfunction

        function void apply_char(logic [15:0] ch);
            case (ch)
                CH_BS:
                begin
                    if (ccol > 0)
                    begin
                        ccol--;
                        delete_cell();
                    end
                end
                CH_TAB:
                begin
                    do
                        store_char(CH_SPACE);
                    while ((ccol % TAB_WIDTH) != 0);
                end
                CH_LF:
                    advance_row();
                CH_CR:
                begin
                    ccol = 0;
                    advance_row();
                end
                CH_ESC:
                begin
                    for (int r = 0; r < rows; r++)
                        for (int c = 0; c < cols; c++)
                            cells[r][c] = CH_SPACE;
                    ccol = 0;
                    crow = 0;
                end
                default:
                    store_char(ch);
            endcase
        endfunction

        // Note an accepted request and queue the result it must produce.
        function void note_request(logic [1:0] f, logic [3:0] key, logic [15:0] ch,
                                   logic [15:0] reps, logic [6:0] rc, logic [5:0] rr);
            caret_result_t expected;
            int unsigned   count;
            logic [15:0]   data;
            data  = '0;
            count = 32'(reps);
            case (f)
                FUNC_KEY:
                    apply_key(key);
                FUNC_CHAR:
                begin
                    // Escape clears once however often it is repeated.
                    if (ch == CH_ESC && count > 1)
                        count = 1;
                    repeat (count)
                        apply_char(ch);
                end
                FUNC_READ:
                    data = (rc < cols && rr < rows) ? cells[rr][rc] : CH_SPACE;
                default:
                    ;
            endcase
            expected.col  = 7'(ccol);
            expected.row  = 6'(crow);
            expected.data = data;
            expected_results.push_back(expected);
        endfunction

        function void check_result(caret_result_t got);
            caret_result_t expected;
            result_count++;
            if (expected_results.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("result %0d with none expected: col %0d row %0d data %h",
                             result_count, got.col, got.row, got.data);
            end
            else
            begin
                expected = expected_results.pop_front();
                if (got.col !== expected.col || got.row !== expected.row ||
                    got.data !== expected.data)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display({"result %0d mismatch: expected col %0d row %0d data %h,",
                                  " got col %0d row %0d data %h"}, result_count,
                                 expected.col, expected.row, expected.data,
                                 got.col, got.row, got.data);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [3:0]  key_code;
    logic [15:0] char_code;
    logic [15:0] repeat_count;
    logic [6:0]  read_col;
    logic [5:0]  read_row;
    logic        out_valid;
    logic        out_stall;
    logic [6:0]  caret_col;
    logic [5:0]  caret_row;
    logic [15:0] cell_data;

    screen_tracker tracker = new();
    int unsigned   burst_left = 0;
    bit            long_hold_req = 1'b0;

    text_cell_buffer_with_caret_unit
    #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    )
    DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .key_code     (key_code),
        .char_code    (char_code),
        .repeat_count (repeat_count),
        .read_col     (read_col),
        .read_row     (read_row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .caret_col    (caret_col),
        .caret_row    (caret_row),
        .cell_data    (cell_data)
    );

    // Free-running 2 ns clock.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Offer one request, inserting a random gap when a burst runs out,
    // and hold it until the block takes it.
    task automatic send_request(input logic [1:0] f, input logic [3:0] key,
                                input logic [15:0] ch, input logic [15:0] reps,
                                input logic [6:0] rc, input logic [5:0] rr);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(1, 8);
        end
        in_valid     <= 1'b1;
        func         <= f;
        key_code     <= key;
        char_code    <= ch;
        repeat_count <= reps;
        read_col     <= rc;
        read_row     <= rr;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        tracker.note_request(f, key, ch, reps, rc, rr);
        burst_left--;
    endtask

    // Random request: mostly well-formed edits and reads, some noise.
    task automatic send_random_request();
        logic [1:0]  f;
        logic [3:0]  key;
        logic [15:0] ch;
        logic [15:0] reps;
        logic [6:0]  rc;
        logic [5:0]  rr;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            f = FUNC_KEY;
        else if (pick < 75)
            f = FUNC_CHAR;
        else if (pick < 95)
            f = FUNC_READ;
        else
            f = FUNC_NONE;

        key = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));

        pick = $urandom_range(0, 99);
        if (pick < 40)
            ch = 16'($urandom_range(16'h21, 16'h7E));
        else if (pick < 50)
            ch = CH_BS;
        else if (pick < 58)
            ch = CH_TAB;
        else if (pick < 66)
            ch = CH_LF;
        else if (pick < 72)
            ch = CH_CR;
        else if (pick < 76)
            ch = CH_ESC;
        else
            ch = 16'($urandom_range(0, 16'hFFFF));

        // Keep repeats short so a request stays cheap; escape runs only once anyway.
        pick = $urandom_range(0, 99);
        if (pick < 6)
            reps = '0;
        else if (pick < 85)
            reps = 16'($urandom_range(1, 4));
        else
            reps = 16'($urandom_range(5, 32));
        if (f != FUNC_CHAR || ch == CH_ESC)
            reps = 16'($urandom_range(0, 16'hFFFF));
        if (f != FUNC_CHAR)
            ch = 16'($urandom_range(0, 16'hFFFF));

        // Reads mostly land on the screen in use, often on the caret row.
        if ($urandom_range(0, 3) == 0)
        begin
            rc = 7'($urandom_range(0, 127));
            rr = 6'($urandom_range(0, 63));
        end
        else
        begin
            rc = 7'($urandom_range(0, tracker.cols - 1));
            rr = $urandom_range(0, 1) ? 6'(tracker.crow) : 6'($urandom_range(0, tracker.rows - 1));
        end
        send_request(f, key, ch, reps, rc, rr);
    endtask

    // Stop offering requests until every expected result has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        tracker.write_register(idx, value);
        cfg_we   <= 1'b0;
        cfg_data <= '0;
    endtask

    // Set a new screen size while the block is idle.
    task automatic configure_screen(input logic [7:0] col_val, input logic [7:0] row_val);
        wait_for_results();
        repeat (IDLE_GUARD) @(posedge clk);
        write_register(REG_COLS, col_val);
        repeat (CLEAR_WAIT) @(posedge clk);
        write_register(REG_ROWS, row_val);
    endtask

    // Result side: stall in stretches of differing density, with one long hold.
    initial
    begin : result_stall_gen
        stall_mode_e mode;
        int unsigned stretch_left;
        stretch_left = 0;
        mode = STALL_NONE;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stretch_left == 0)
            begin
                if (long_hold_req)
                begin
                    long_hold_req = 1'b0;
                    mode = STALL_HOLD;
                    stretch_left = LONG_HOLD;
                end
                else
                begin
                    mode = stall_mode_e'($urandom_range(STALL_NONE, STALL_HEAVY));
                    stretch_left = $urandom_range(4, 40);
                end
            end
            stretch_left--;
            case (mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= 1'b1;
            endcase
        end
    end

    // Collect every accepted result and check it against the tracker.
    initial
    begin : result_monitor
        caret_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.col  = caret_col;
                got.row  = caret_row;
                got.data = cell_data;
                tracker.check_result(got);
            end
        end
    end

    // Main sequence: reset, directed requests, then random phases per screen size.
    initial
    begin : stimulus
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_COLS;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        func         <= FUNC_KEY;
        key_code     <= KEY_HOME;
        char_code    <= '0;
        repeat_count <= '0;
        read_col     <= '0;
        read_row     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset screen reads as spaces, and a read outside the screen in use returns a space.
        send_request(FUNC_READ, KEY_HOME, 16'h0000, 16'd0, 7'd0, 6'd0);
        send_request(FUNC_READ, KEY_HOME, 16'h0000, 16'd0, 7'd127, 6'd63);
        // Caret to the bottom right corner, then push against both edges.
        send_request(FUNC_KEY, KEY_END, 16'h0000, 16'd0, 7'd0, 6'd0);
        send_request(FUNC_KEY, KEY_PGDN, 16'h0000, 16'd0, 7'd0, 6'd0);
        send_request(FUNC_KEY, KEY_RIGHT, 16'h0000, 16'd0, 7'd0, 6'd0);
        send_request(FUNC_KEY, KEY_DOWN, 16'h0000, 16'd0, 7'd0, 6'd0);
        // A character in the last cell wraps the caret back to the top left.
        send_request(FUNC_CHAR, KEY_HOME, 16'h005A, 16'd1, 7'd0, 6'd0);
        send_request(FUNC_READ, KEY_HOME, 16'h0000, 16'd0, 7'd79, 6'd24);
        send_request(FUNC_KEY, KEY_LEFT, 16'h0000, 16'd0, 7'd0, 6'd0);
        send_request(FUNC_KEY, KEY_UP, 16'h0000, 16'd0, 7'd0, 6'd0);
        // Backspace at column zero does nothing; a zero repeat does nothing.
        send_request(FUNC_CHAR, KEY_HOME, CH_BS, 16'd1, 7'd0, 6'd0);
        send_request(FUNC_CHAR, KEY_HOME, 16'hFFFF, 16'd3, 7'd0, 6'd0);
        send_request(FUNC_CHAR, KEY_HOME, 16'h0061, 16'd0, 7'd0, 6'd0);
        // Tab runs to the next stop; from a tab stop it still writes a full stop's worth of spaces.
        send_request(FUNC_CHAR, KEY_HOME, CH_TAB, 16'd2, 7'd0, 6'd0);
        send_request(FUNC_CHAR, KEY_HOME, 16'h0078, 16'd200, 7'd0, 6'd0);
        send_request(FUNC_CHAR, KEY_HOME, CH_LF, 16'd3, 7'd0, 6'd0);
        send_request(FUNC_CHAR, KEY_HOME, CH_CR, 16'd1, 7'd0, 6'd0);
        send_request(FUNC_KEY, KEY_UP, 16'h0000, 16'd0, 7'd0, 6'd0);
        send_request(FUNC_KEY, KEY_DELETE, 16'h0000, 16'd0, 7'd0, 6'd0);
        send_request(FUNC_KEY, KEY_END, 16'h0000, 16'd0, 7'd0, 6'd0);
        send_request(FUNC_CHAR, KEY_HOME, CH_BS, 16'd2, 7'd0, 6'd0);
        // Unknown key codes and the unused function leave everything alone.
        send_request(FUNC_KEY, 4'hF, 16'h0000, 16'd0, 7'd0, 6'd0);
        send_request(FUNC_NONE, KEY_HOME, 16'h0000, 16'd0, 7'd0, 6'd0);
        send_request(FUNC_READ, KEY_HOME, 16'h0000, 16'd0, 7'd3, 6'd2);
        // Escape clears once even with a huge repeat; a second escape is harmless.
        send_request(FUNC_CHAR, KEY_HOME, CH_ESC, 16'hFFFF, 7'd0, 6'd0);
        send_request(FUNC_CHAR, KEY_HOME, CH_ESC, 16'd1, 7'd0, 6'd0);
        send_request(FUNC_CHAR, KEY_HOME, 16'h0000, 16'd1, 7'd0, 6'd0);
        send_request(FUNC_KEY, KEY_PGUP, 16'h0000, 16'd0, 7'd0, 6'd0);

        // Largest screen.
        configure_screen(8'd128, 8'd64);
        repeat (12) send_random_request();

        // Smallest screen.
        configure_screen(8'd1, 8'd1);
        repeat (8) send_random_request();

        // Out-of-range values saturate: one full-width row.
        configure_screen(8'hFF, 8'h00);
        repeat (8) send_random_request();

        // One column, all rows.
        configure_screen(8'h00, 8'hFF);
        repeat (8) send_random_request();

        // Mid-size screen with a long receiver hold and a full drain.
        configure_screen(8'($urandom_range(2, 40)), 8'($urandom_range(2, 16)));
        long_hold_req = 1'b1;
        repeat (16) send_random_request();
        wait_for_results();
        repeat (10) send_random_request();

        // Small screen where wraps come quickly.
        configure_screen(8'd8, 8'd3);
        repeat (10) send_random_request();

        wait_for_results();
        repeat (IDLE_GUARD) @(posedge clk);
        if (tracker.error_count == 0 && tracker.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Give up if the run hangs.
    initial
    begin : run_limit
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/tcb_pkg.sv
hw/rtl/tcb_ctrl.sv
hw/rtl/tcb_datapath.sv
hw/rtl/text_cell_buffer_with_caret_unit.sv
bench/text_cell_buffer_with_caret_unit_tb.sv
